// File: sv/pbcd_pkg.sv
// Package for the packed BCD / binary converter: word types, mode codes and
// pipeline sizing constants. No dependencies.
package pbcd_pkg;

	localparam int DIGIT_BYTES    = 9;
	localparam int MAG_W          = 64;
	localparam int OUT_MAG_W      = 61;
	localparam int BCD_DIGITS     = 20;
	localparam int BCD_W          = 4 * BCD_DIGITS;
	localparam int BITS_PER_STAGE = 4;
	localparam int NUM_STAGES     = MAG_W / BITS_PER_STAGE;
	localparam int PACK_W         = 8 * DIGIT_BYTES;

	localparam logic [71:0] BYTES_MASK =
		(DIGIT_BYTES >= 9) ? {72{1'b1}} : ((72'd1 << (8 * DIGIT_BYTES)) - 72'd1);

	localparam logic [7:0] SIGN_NEG  = 8'h80;
	localparam logic [3:0] DIGIT_MAX = 4'd9;
	localparam logic [3:0] NIB_MASK  = 4'hf;

	typedef enum logic {
		MODE_LOAD  = 1'b0,
		MODE_STORE = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [63:0] bcd_digits_low;
		logic [7:0]  bcd_digits_top;
		logic [7:0]  bcd_sign_byte;
		logic [63:0] magnitude_in;
		logic        negative_in;
	} pbcd_in_t;

	typedef struct packed {
		logic [OUT_MAG_W-1:0] magnitude_out;
		logic                 negative_out;
		logic [63:0]          packed_low_out;
		logic [7:0]           packed_top_out;
		logic [7:0]           packed_sign_out;
		logic                 digits_lost;
	} pbcd_out_t;

	typedef struct packed {
		mode_t            mode;
		logic             sgn;
		logic [MAG_W-1:0] bin;
		logic [BCD_W-1:0] bcd;
	} pbcd_stage_t;

endpackage

// File: sv/packed_bcd_binary_converter.sv
// Packed BCD / binary converter, top level: 16-stage pipeline plus input register.
// Depends on pbcd_pkg.
//
// One word is taken per clock; busy is always low. The result appears on
// result with done high once the word has passed the input register and all
// pipeline stages, and results leave in order.
// Load words fold one packed byte per stage (multiply by 100 and add); store
// words run four shift-add-3 steps per stage over 16 stages to split the
// 64-bit magnitude into 20 decimal digits, of which the top two set
// digits_lost. The receiver cannot stall the pipeline.
module packed_bcd_binary_converter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  pbcd_pkg::pbcd_in_t  cmd,
	output logic                done,
	output pbcd_pkg::pbcd_out_t result
);

	localparam int NS = pbcd_pkg::NUM_STAGES;

	logic                  valid_s [0:NS];
	pbcd_pkg::pbcd_stage_t pipe_s  [0:NS];
	pbcd_pkg::pbcd_stage_t pipe_nxt[1:NS];
	logic                  accept;
	logic [71:0]           in_bytes;

	function automatic pbcd_pkg::pbcd_stage_t dabble(input pbcd_pkg::pbcd_stage_t s);
		pbcd_pkg::pbcd_stage_t r;
		logic [pbcd_pkg::BCD_W-1:0] b;
		r = s;
		for (int k = 0; k < pbcd_pkg::BITS_PER_STAGE; k++) begin
			b = r.bcd;
			for (int d = 0; d < pbcd_pkg::BCD_DIGITS; d++) begin
				if (b[4*d +: 4] > 4'd4)
					b[4*d +: 4] = b[4*d +: 4] + 4'd3;
			end
			r.bcd = {b[pbcd_pkg::BCD_W-2:0], r.bin[pbcd_pkg::MAG_W-1]};
			r.bin = {r.bin[pbcd_pkg::MAG_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic pbcd_pkg::pbcd_stage_t fold(input pbcd_pkg::pbcd_stage_t s);
		pbcd_pkg::pbcd_stage_t r;
		logic [7:0] byte_v;
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] val;
		r      = s;
		byte_v = s.bcd[pbcd_pkg::PACK_W-1 -: 8];
		hi     = {4'd0, byte_v[7:4]};
		lo     = {4'd0, byte_v[3:0] & pbcd_pkg::NIB_MASK};
		val    = (hi << 3) + (hi << 1) + lo;
		r.bin  = (s.bin << 6) + (s.bin << 5) + (s.bin << 2)
		         + {{(pbcd_pkg::MAG_W-8){1'b0}}, val};
		r.bcd  = s.bcd << 8;
		return r;
	endfunction

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign in_bytes = {cmd.bcd_digits_top, cmd.bcd_digits_low} & pbcd_pkg::BYTES_MASK;

	always_comb begin
		for (int g = 1; g <= NS; g++) begin
			if (pipe_s[g-1].mode == pbcd_pkg::MODE_STORE)
				pipe_nxt[g] = dabble(pipe_s[g-1]);
			else if (g <= pbcd_pkg::DIGIT_BYTES)
				pipe_nxt[g] = fold(pipe_s[g-1]);
			else
				pipe_nxt[g] = pipe_s[g-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g <= NS; g++)
				valid_s[g] <= 1'b0;
		end else begin
			valid_s[0] <= accept;
			for (int g = 1; g <= NS; g++)
				valid_s[g] <= valid_s[g-1];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pipe_s[0].mode <= cmd.mode;
			if (cmd.mode == pbcd_pkg::MODE_STORE) begin
				pipe_s[0].sgn <= cmd.negative_in;
				pipe_s[0].bin <= cmd.magnitude_in;
				pipe_s[0].bcd <= '0;
			end else begin
				pipe_s[0].sgn <= cmd.bcd_sign_byte[7];
				pipe_s[0].bin <= '0;
				pipe_s[0].bcd <= {{(pbcd_pkg::BCD_W-72){1'b0}}, in_bytes};
			end
		end
		for (int g = 1; g <= NS; g++)
			pipe_s[g] <= pipe_nxt[g];
	end

	always_comb begin
		result = '0;
		if (pipe_s[NS].mode == pbcd_pkg::MODE_LOAD) begin
			result.magnitude_out = pipe_s[NS].bin[pbcd_pkg::OUT_MAG_W-1:0];
			result.negative_out  = pipe_s[NS].sgn;
		end else begin
			result.packed_low_out  = pipe_s[NS].bcd[63:0] & pbcd_pkg::BYTES_MASK[63:0];
			result.packed_top_out  = pipe_s[NS].bcd[71:64] & pbcd_pkg::BYTES_MASK[71:64];
			result.packed_sign_out = pipe_s[NS].sgn ? pbcd_pkg::SIGN_NEG : 8'h00;
			result.digits_lost     = |pipe_s[NS].bcd[pbcd_pkg::BCD_W-1:pbcd_pkg::PACK_W];
		end
	end

	assign done = valid_s[NS];

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(NS+1) done)
		else $error("word accepted without result after pipeline latency");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, NS+1))
		else $error("result strobe without matching accepted word");

	a_sign_code: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.packed_sign_out != 8'h00 |->
			result.packed_sign_out == pbcd_pkg::SIGN_NEG && result.magnitude_out == '0)
		else $error("bad sign byte or mixed load/store fields");

	a_lost_store: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.digits_lost |-> result.magnitude_out == '0 && !result.negative_out)
		else $error("digits_lost set on a load result");
`endif

endmodule
